FILE: rtl/motor_current_window_monitor_macros.svh
// Assertion macros shared by the motor current window monitor RTL.
`ifndef MOTOR_CURRENT_WINDOW_MONITOR_MACROS_SVH
`define MOTOR_CURRENT_WINDOW_MONITOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MCWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcwm assertion failed");

// Next-cycle implication, disabled during reset.
`define MCWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcwm assertion failed");

`endif

FILE: rtl/mcwm_pkg.sv
// Package: widths, command/status/register codes and shared structs.
`default_nettype none

package mcwm_pkg;

  localparam int SampleW  = 12;
  localparam int TimeW    = 32;
  localparam int CmdW     = 2;
  localparam int StatusW  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [CmdW-1:0] CmdStart  = 2'd0;
  localparam logic [CmdW-1:0] CmdSample = 2'd1;
  localparam logic [CmdW-1:0] CmdStop   = 2'd2;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StOver  = 2'd1;
  localparam logic [StatusW-1:0] StUnder = 2'd2;

  localparam logic [CfgIdxW-1:0] RegUnderLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOverLimit  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBlanking   = 2'd2;

  localparam logic [SampleW-1:0] OverLimitRst = 12'hFFF;

  typedef struct packed {
    logic [SampleW-1:0] under_limit;
    logic [SampleW-1:0] over_limit;
    logic [TimeW-1:0]   blanking_ms;
  } cfg_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               changed;
    logic               active;
  } flags_t;

endpackage

`default_nettype wire

FILE: rtl/mcwm_cfg_regs.sv
// Configuration register file: limits and blanking window.
`default_nettype none

module mcwm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [mcwm_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [mcwm_pkg::CfgDataW-1:0] wr_data_i,
  output mcwm_pkg::cfg_t                cfg_o
);
  import mcwm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        RegUnderLimit: cfg_d.under_limit = wr_data_i[SampleW-1:0];
        RegOverLimit:  cfg_d.over_limit  = wr_data_i[SampleW-1:0];
        RegBlanking:   cfg_d.blanking_ms = wr_data_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.under_limit <= '0;
      cfg_q.over_limit  <= OverLimitRst;
      cfg_q.blanking_ms <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/mcwm_core.sv
// Monitor state: sample ring, running sum, blanking timer and status update.
`default_nettype none

module mcwm_core #(
  parameter  int AvgDepth = 8,
  localparam int SumW     = mcwm_pkg::SampleW + $clog2(AvgDepth)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mcwm_pkg::cfg_t               cfg_i,
  input  logic                         fire_i,
  input  logic [mcwm_pkg::CmdW-1:0]    cmd_i,
  input  logic [mcwm_pkg::SampleW-1:0] sample_i,
  input  logic [mcwm_pkg::TimeW-1:0]   time_i,
  output logic [SumW-1:0]              sum_o,
  output mcwm_pkg::flags_t             flags_o
);
  import mcwm_pkg::*;

  localparam int HeadW = (AvgDepth > 1) ? $clog2(AvgDepth) : 1;
  localparam int ThrW  = SumW + 1;
  localparam logic [HeadW-1:0] HeadLast = HeadW'(AvgDepth - 1);
  localparam logic [ThrW-1:0]  DepthThr = ThrW'(AvgDepth);
  localparam logic [SumW-1:0]  DepthSum = SumW'(AvgDepth);

  logic [SampleW-1:0] ring_q [AvgDepth];
  logic [HeadW-1:0]   head_q, head_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic               on_q, on_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [TimeW-1:0]   stamp_q, stamp_d;

  logic [SampleW-1:0] oldest;
  logic [SumW-1:0]    sum_smp;
  logic [ThrW-1:0]    over_thr, under_thr;
  logic [TimeW-1:0]   elapsed;
  logic               over_hit, under_hit, armed;
  logic [StatusW-1:0] next_status;
  logic               changed, do_start, do_sample;

  assign oldest    = ring_q[head_q];
  assign sum_smp   = sum_q - SumW'(oldest) + SumW'(sample_i);
  // avg > over  <=>  sum >= (over+1)*D ;  avg < under  <=>  sum < under*D
  assign over_thr  = (ThrW'(cfg_i.over_limit) + ThrW'(1)) * DepthThr;
  assign under_thr = ThrW'(cfg_i.under_limit) * DepthThr;
  assign over_hit  = ThrW'(sum_smp) >= over_thr;
  assign under_hit = ThrW'(sum_smp) < under_thr;
  assign elapsed   = time_i - stamp_q;
  assign armed     = elapsed > cfg_i.blanking_ms;

  always_comb begin
    if (!armed)         next_status = StOk;
    else if (over_hit)  next_status = StOver;
    else if (under_hit) next_status = StUnder;
    else                next_status = StOk;
  end

  always_comb begin
    head_d    = head_q;
    sum_d     = sum_q;
    on_d      = on_q;
    status_d  = status_q;
    stamp_d   = stamp_q;
    changed   = 1'b0;
    do_start  = 1'b0;
    do_sample = 1'b0;
    if (fire_i) begin
      case (cmd_i)
        CmdStart: begin
          if (!on_q) begin
            do_start = 1'b1;
            sum_d    = SumW'(sample_i) * DepthSum;
            head_d   = '0;
            status_d = StOk;
            stamp_d  = time_i;
            on_d     = 1'b1;
          end
        end
        CmdSample: begin
          if (on_q) begin
            do_sample = 1'b1;
            sum_d     = sum_smp;
            head_d    = (head_q == HeadLast) ? '0 : head_q + HeadW'(1);
            status_d  = next_status;
            changed   = next_status != status_q;
          end
        end
        CmdStop: on_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      sum_q    <= '0;
      on_q     <= 1'b0;
      status_q <= StOk;
      stamp_q  <= '0;
    end else begin
      head_q   <= head_d;
      sum_q    <= sum_d;
      on_q     <= on_d;
      status_q <= status_d;
      stamp_q  <= stamp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_start) begin
      for (int i = 0; i < AvgDepth; i++) begin
        ring_q[i] <= sample_i;
      end
    end else if (do_sample) begin
      ring_q[head_q] <= sample_i;
    end
  end

  assign sum_o           = sum_d;
  assign flags_o.status  = status_d;
  assign flags_o.changed = changed;
  assign flags_o.active  = on_d;

endmodule

`default_nettype wire

FILE: rtl/mcwm_avg_div.sv
// Running sum to average: divide by the ring depth via reciprocal multiply.
`default_nettype none

module mcwm_avg_div #(
  parameter  int AvgDepth = 8,
  localparam int SumW     = mcwm_pkg::SampleW + $clog2(AvgDepth)
) (
  input  logic [SumW-1:0]              sum_i,
  output logic [mcwm_pkg::SampleW-1:0] avg_o
);
  import mcwm_pkg::*;

  localparam int Shift = SumW + $clog2(AvgDepth);
  localparam int ProdW = 2 * SumW + 1;
  localparam longint unsigned Recip =
    ((64'd1 << Shift) + 64'(AvgDepth) - 64'd1) / 64'(AvgDepth);
  localparam logic [SumW:0] RecipW = (SumW + 1)'(Recip);

  logic [ProdW-1:0] product;

  assign product = ProdW'(sum_i) * ProdW'(RecipW);
  assign avg_o   = product[Shift +: SampleW];

endmodule

`default_nettype wire

FILE: rtl/motor_current_window_monitor.sv
// Top level: motor current moving-average window monitor.
//
//   Channel  Dir  Payload                                   Handshake
//   in       in   command, adc_sample, time_ms              in_valid_i / in_ready_o
//   out      out  status, status_changed, average,          out_valid_o / out_ready_i
//                 sample_echo, active
//   cfg      in   cfg_index_i, cfg_data_i                   cfg_valid_i / cfg_ready_o
//
// One transaction per cycle sustained while out_ready_i is high; an accepted input
// passes the input register, then the state update into the result register.
// The average is a reciprocal multiply on the result register's sum.
// Reset clears state at once; no clearing pass. cfg_ready_o is always high.
// With out_ready_i low the result holds, the input register fills, then in_ready_o drops.
`default_nettype none

module motor_current_window_monitor #(
  parameter int AVG_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mcwm_pkg::CmdW-1:0]     command_i,
  input  logic [mcwm_pkg::SampleW-1:0]  adc_sample_i,
  input  logic [mcwm_pkg::TimeW-1:0]    time_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mcwm_pkg::StatusW-1:0]  status_o,
  output logic                          status_changed_o,
  output logic [mcwm_pkg::SampleW-1:0]  average_o,
  output logic [mcwm_pkg::SampleW-1:0]  sample_echo_o,
  output logic                          active_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mcwm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mcwm_pkg::CfgDataW-1:0] cfg_data_i
);
  import mcwm_pkg::*;
  `include "motor_current_window_monitor_macros.svh"

  localparam int SumW = SampleW + $clog2(AVG_DEPTH);

  cfg_t               cfg;
  logic               s1_valid_q, s1_valid_d;
  logic [CmdW-1:0]    s1_cmd_q;
  logic [SampleW-1:0] s1_sample_q;
  logic [TimeW-1:0]   s1_time_q;
  logic               s1_fire, in_fire;
  logic               out_valid_q, out_valid_d;
  logic [SumW-1:0]    core_sum, res_sum_q;
  flags_t             core_flags, res_flags_q;
  logic [SampleW-1:0] res_sample_q;

  assign cfg_ready_o = 1'b1;
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_fire;
  assign in_fire     = in_valid_i && in_ready_o;
  assign s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  mcwm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  mcwm_core #(.AvgDepth(AVG_DEPTH)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (s1_fire),
    .cmd_i    (s1_cmd_q),
    .sample_i (s1_sample_q),
    .time_i   (s1_time_q),
    .sum_o    (core_sum),
    .flags_o  (core_flags)
  );

  mcwm_avg_div #(.AvgDepth(AVG_DEPTH)) u_div (
    .sum_i (res_sum_q),
    .avg_o (average_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q    <= command_i;
      s1_sample_q <= adc_sample_i;
      s1_time_q   <= time_ms_i;
    end
    if (s1_fire) begin
      res_sum_q    <= core_sum;
      res_flags_q  <= core_flags;
      res_sample_q <= s1_sample_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_flags_q.status;
  assign status_changed_o = res_flags_q.changed;
  assign sample_echo_o    = res_sample_q;
  assign active_o         = res_flags_q.active;

  `MCWM_ASSERT_NOW(a_changed_needs_active, clk_i, rst_ni, out_valid_q && res_flags_q.changed, res_flags_q.active)
  `MCWM_ASSERT_NOW(a_full_accept_drains, clk_i, rst_ni, in_fire && s1_valid_q, s1_fire)
  `MCWM_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, s1_fire, out_valid_q)

endmodule

`default_nettype wire

FILE: test/motor_current_window_monitor_tb.sv
// Self-checking testbench for the motor current window monitor, with a scoreboard predictor.
module motor_current_window_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcwm_pkg::*;

  localparam int AVG_DEPTH = 8;
  localparam int SumW = SampleW + 3;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [CmdW-1:0] CmdNop = 2'd3;
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               changed;
    logic [SampleW-1:0] average;
    logic [SampleW-1:0] echo;
    logic               active;
  } result_t;

  class current_scoreboard;
    logic [SampleW-1:0] under_lim;
    logic [SampleW-1:0] over_lim;
    logic [TimeW-1:0]   blank_win;
    logic [SampleW-1:0] ring[AVG_DEPTH];
    logic [SumW-1:0]    sum;
    int unsigned        head;
    bit                 on;
    logic [StatusW-1:0] status;
    logic [TimeW-1:0]   start_ms;
    result_t            expected_q[$];
    int unsigned        errors;

    function new();
      under_lim = '0;
      over_lim  = OverLimitRst;
      blank_win = '0;
      foreach (ring[i]) ring[i] = '0;
      sum      = '0;
      head     = 0;
      on       = 1'b0;
      status   = StOk;
      start_ms = '0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegUnderLimit: under_lim = data[SampleW-1:0];
        RegOverLimit:  over_lim  = data[SampleW-1:0];
        RegBlanking:   blank_win = data[TimeW-1:0];
        default: ;
      endcase
    endfunction

    function logic [SampleW-1:0] mean();
      logic [SumW-1:0] q;
      q = sum / SumW'(AVG_DEPTH);
      return q[SampleW-1:0];
    endfunction

    function void note_input(logic [CmdW-1:0] cmd, logic [SampleW-1:0] smp,
                             logic [TimeW-1:0] now_ms);
      result_t            r;
      logic [StatusW-1:0] next;
      logic [TimeW-1:0]   elapsed;
      logic [SampleW-1:0] avg;
      r.changed = 1'b0;
      case (cmd)
        CmdStart: begin
          if (!on) begin
            foreach (ring[i]) ring[i] = smp;
            sum      = SumW'(smp) * SumW'(AVG_DEPTH);
            head     = 0;
            status   = StOk;
            start_ms = now_ms;
            on       = 1'b1;
          end
        end
        CmdSample: begin
          if (on) begin
            sum = sum - SumW'(ring[head]) + SumW'(smp);
            ring[head] = smp;
            head = (head + 1) % AVG_DEPTH;
            avg = mean();
            elapsed = now_ms - start_ms;
            next = StOk;
            if (elapsed > blank_win) begin
              if (avg > over_lim) next = StOver;
              else if (avg < under_lim) next = StUnder;
            end
            if (next != status) begin
              status    = next;
              r.changed = 1'b1;
            end
          end
        end
        CmdStop: on = 1'b0;
        default: ;
      endcase
      r.status  = status;
      r.average = mean();
      r.echo    = smp;
      r.active  = on;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (errors < 30) $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no transaction pending");
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.changed !== want.changed)
        report_mismatch($sformatf("status_changed got %0d want %0d", got.changed, want.changed));
      if (got.average !== want.average)
        report_mismatch($sformatf("average got %0d want %0d", got.average, want.average));
      if (got.echo !== want.echo)
        report_mismatch($sformatf("sample_echo got %0d want %0d", got.echo, want.echo));
      if (got.active !== want.active)
        report_mismatch($sformatf("active got %0d want %0d", got.active, want.active));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [CmdW-1:0]     command_i = CmdNop;
  logic [SampleW-1:0]  adc_sample_i = '0;
  logic [TimeW-1:0]    time_ms_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic                status_changed_o;
  logic [SampleW-1:0]  average_o;
  logic [SampleW-1:0]  sample_echo_o;
  logic                active_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  current_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_cnt = 0;
  logic [TimeW-1:0] now_ms = '0;

  motor_current_window_monitor #(
    .AVG_DEPTH(AVG_DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .adc_sample_i    (adc_sample_i),
    .time_ms_i       (time_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .status_changed_o(status_changed_o),
    .average_o       (average_o),
    .sample_echo_o   (sample_echo_o),
    .active_o        (active_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({status_o, status_changed_o, average_o, sample_echo_o, active_o});
  end

  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [SampleW-1:0] smp,
                           input logic [TimeW-1:0] stamp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    adc_sample_i <= smp;
    time_ms_i    <= stamp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(cmd, smp, stamp);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // upper data bits are random to check that the limits take only 12 bits
  task automatic program_limits(input int unsigned under_val, input int unsigned over_val,
                                input logic [TimeW-1:0] blank_val);
    put_reg(RegUnderLimit, ($urandom() & 32'hFFFF_F000) | (under_val & 32'hFFF));
    put_reg(RegOverLimit, ($urandom() & 32'hFFFF_F000) | (over_val & 32'hFFF));
    put_reg(RegBlanking, blank_val);
    put_reg(RegSpare, $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_segment(input int unsigned quota);
    int unsigned done_cnt;
    int unsigned len;
    int          level;
    int          spread;
    int          v;
    logic [CmdW-1:0] c;
    done_cnt = 0;
    while (done_cnt < quota) begin
      if ($urandom_range(3) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 60);
      else if ($urandom_range(3) == 0) now_ms = $urandom();
      send_item(CmdStart, SampleW'($urandom()), now_ms);
      done_cnt++;
      len = $urandom_range(4, 40);
      level = $urandom_range(0, 4095);
      case ($urandom_range(2))
        0: spread = 0;
        1: spread = 64;
        default: spread = 4095;
      endcase
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(19) == 0) begin
          c = $urandom_range(1) ? CmdStart : CmdNop;
          send_item(c, SampleW'($urandom()), now_ms);
        end else begin
          now_ms = now_ms + $urandom_range(0, 12);
          v = level + $urandom_range(0, 2 * spread) - spread;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          send_item(CmdSample, SampleW'(v), now_ms);
          done_cnt++;
        end
      end
      send_item(CmdStop, SampleW'($urandom()), now_ms);
      done_cnt++;
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(2))
          0: c = CmdSample;
          1: c = CmdStop;
          default: c = CmdNop;
        endcase
        send_item(c, SampleW'($urandom()), $urandom());
      end
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 27;
    recv_idle_pct = 47;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: nothing can leave the ok window
    send_item(CmdSample, 12'hFFF, 32'hFFFF_FFFF);
    send_item(CmdNop, 12'hFFF, 32'hFFFF_FFFF);
    send_item(CmdStart, 12'hFFF, 32'h0000_0000);
    send_item(CmdSample, 12'h000, 32'h0000_0001);
    send_item(CmdStop, 12'h000, 32'h0000_0002);
    wait_drained();
    program_limits(1000, 3000, 32'd16);

    // blanking across the timestamp wrap, then over, under and restart cases
    send_item(CmdStart, 12'h000, 32'hFFFF_FFF0);
    send_item(CmdStart, 12'hFFF, 32'hFFFF_FFF1);
    send_item(CmdSample, 12'hFFF, 32'hFFFF_FFF8);
    send_item(CmdSample, 12'hFFF, 32'h0000_0000);
    send_item(CmdSample, 12'hFFF, 32'h0000_0001);
    for (int k = 0; k < 4; k++) send_item(CmdSample, 12'hFFF, 32'h0000_0002 + k);
    for (int k = 0; k < 7; k++) send_item(CmdSample, 12'h000, 32'h0000_0010 + k);
    send_item(CmdStop, 12'h123, 32'h0000_0020);
    send_item(CmdStop, 12'h456, 32'h0000_0021);
    send_item(CmdSample, 12'd2000, 32'h0000_0022);
    send_item(CmdStart, 12'd2000, 32'h0000_0023);

    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      case (seg)
        0: program_limits(1200, 2800, 32'd50);
        1: program_limits(4095, 0, 32'd0);
        2: program_limits($urandom_range(0, 2000), $urandom_range(2000, 4095),
                          $urandom_range(0, 200));
        3: program_limits(0, 4095, 32'hFFFF_FFFF);
        4: program_limits($urandom_range(0, 2000), $urandom_range(2000, 4095),
                          $urandom_range(0, 300));
        default: program_limits($urandom_range(0, 4095), $urandom_range(0, 4095),
                                $urandom_range(0, 100));
      endcase
      send_idle_pct = (seg < 2) ? 27 : (seg < 4) ? 47 : 0;
      recv_idle_pct = (seg < 2) ? 47 : (seg < 4) ? 27 : 0;
      run_segment(200);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mcwm_pkg.sv
rtl/mcwm_cfg_regs.sv
rtl/mcwm_core.sv
rtl/mcwm_avg_div.sv
rtl/motor_current_window_monitor.sv
test/motor_current_window_monitor_tb.sv
